// ===== sv/box_filter_3x3_zero_border_unit_macros.svh =====
// Assertion macros shared by the 3x3 box filter modules.
// No dependencies; included by every file that carries assertions.
`ifndef BOX_FILTER_3X3_ZERO_BORDER_UNIT_MACROS_SVH
`define BOX_FILTER_3X3_ZERO_BORDER_UNIT_MACROS_SVH

// same-cycle implication
`define BF3Z_ASSERT_IMM(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BF3Z_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/bf3z_pkg.sv =====
// Shared types, constants and helpers of the 3x3 box filter.
// No dependencies; imported by every module of the block.
package bf3z_pkg;

    localparam int MAX_SIZE     = 1024;
    localparam int SAMPLE_BITS  = 16;
    localparam int POS_BITS     = 11;
    localparam int ADDR_BITS    = $clog2(MAX_SIZE);
    localparam int ROW_BITS     = SAMPLE_BITS + 2;
    localparam int SUM_BITS     = SAMPLE_BITS + 4;
    localparam int MAG_BITS     = SUM_BITS;
    localparam int DIV_MUL_BITS = 18;
    localparam int DIV_SHIFT    = 21;
    localparam int PROD_BITS    = MAG_BITS + DIV_MUL_BITS;
    localparam int QUO_BITS     = PROD_BITS - DIV_SHIFT;
    localparam int Q_DEPTH      = 4;
    localparam int Q_PTR_BITS   = $clog2(Q_DEPTH);

    // ceil(2^21 / 9): exact floor division by 9 for all magnitudes in range
    localparam logic [DIV_MUL_BITS-1:0] DIV_MUL = DIV_MUL_BITS'(233017);

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_DRAIN  = 1'b1;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic [ADDR_BITS-1:0]          addr_t;
    typedef logic [POS_BITS-1:0]           pos_t;

    typedef struct packed {
        sample_t s;
        addr_t   addr;
        logic    has_result;
        logic    keep_top;
        logic    keep_bot;
        logic    keep_left;
        logic    keep_right;
        logic    last;
    } item_t;

    function automatic pos_t eff_size(pos_t v);
        pos_t n;
        n = v;
        if (v == '0) begin
            n = POS_BITS'(1);
        end else if (v > POS_BITS'(MAX_SIZE)) begin
            n = POS_BITS'(MAX_SIZE);
        end
        return n;
    endfunction

endpackage

// ===== sv/bf3z_front.sv =====
// Front end: accepts items, tracks the raster position and classifies each item.
// Depends on bf3z_pkg; feeds bf3z_queue.
module bf3z_front (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [bf3z_pkg::POS_BITS-1:0] cfg_data,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic                       s_cmd,
    input  bf3z_pkg::sample_t          s_sample_in,
    input  logic                       q_full,
    output logic                       q_push,
    output bf3z_pkg::item_t            q_item
);
    import bf3z_pkg::*;

    pos_t row_reg, row_next;
    pos_t col_reg, col_next;
    pos_t n_reg;
    pos_t nm1_reg;

    logic in_grid;
    logic ignore;
    logic col_nz;
    logic has_result;
    logic last;
    pos_t cr;
    pos_t cc;
    pos_t col_inc;

    assign cfg_ready = 1'b1;
    assign s_ready   = !q_full;

    always_comb begin
        in_grid    = row_reg < n_reg;
        ignore     = in_grid && (s_cmd == CMD_DRAIN);
        q_push     = s_valid && s_ready && !ignore;
        col_nz     = col_reg != '0;
        has_result = col_nz ? (row_reg >= POS_BITS'(1)) : (row_reg >= POS_BITS'(2));
        cr         = col_nz ? row_reg - POS_BITS'(1) : row_reg - POS_BITS'(2);
        cc         = col_nz ? col_reg - POS_BITS'(1) : nm1_reg;
        last       = has_result && (cr == nm1_reg) && (cc == nm1_reg);

        q_item.s          = in_grid ? s_sample_in : '0;
        q_item.addr       = col_reg[ADDR_BITS-1:0];
        q_item.has_result = has_result;
        q_item.keep_top   = cr != '0;
        q_item.keep_bot   = cr != nm1_reg;
        q_item.keep_left  = cc != '0;
        q_item.keep_right = cc != nm1_reg;
        q_item.last       = last;

        col_inc  = col_reg + POS_BITS'(1);
        row_next = row_reg;
        col_next = col_inc;
        if (last) begin
            row_next = '0;
            col_next = '0;
        end else if (col_inc == n_reg) begin
            row_next = row_reg + POS_BITS'(1);
            col_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg <= '0;
            col_reg <= '0;
            n_reg   <= POS_BITS'(MAX_SIZE);
            nm1_reg <= POS_BITS'(MAX_SIZE - 1);
        end else if (cfg_valid && cfg_ready) begin
            row_reg <= '0;
            col_reg <= '0;
            n_reg   <= eff_size(cfg_data);
            nm1_reg <= eff_size(cfg_data) - POS_BITS'(1);
        end else if (q_push) begin
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

endmodule

// ===== sv/bf3z_queue.sv =====
// Short item queue between the front end and the filter back end.
// Depends on bf3z_pkg.
`include "box_filter_3x3_zero_border_unit_macros.svh"
module bf3z_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  bf3z_pkg::item_t push_item,
    output logic            full,
    input  logic            pop,
    output logic            head_valid,
    output bf3z_pkg::item_t head_item
);
    import bf3z_pkg::*;

    item_t                 q_mem [Q_DEPTH];
    logic [Q_PTR_BITS-1:0] wr_ptr_reg;
    logic [Q_PTR_BITS-1:0] rd_ptr_reg;
    logic [Q_PTR_BITS:0]   count_reg, count_next;

    assign full       = count_reg == (Q_PTR_BITS + 1)'(Q_DEPTH);
    assign head_valid = count_reg != '0;
    assign head_item  = q_mem[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + (Q_PTR_BITS + 1)'(1);
        end else if (pop && !push) begin
            count_next = count_reg - (Q_PTR_BITS + 1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + Q_PTR_BITS'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + Q_PTR_BITS'(1);
            end
            count_reg <= count_next;
        end
    end

    `BF3Z_ASSERT_IMM(a_no_push_full, aclk, aresetn, push, !full || pop, "push into full queue")
    `BF3Z_ASSERT_IMM(a_no_pop_empty, aclk, aresetn, pop, head_valid, "pop from empty queue")

endmodule

// ===== sv/bf3z_back.sv =====
// Back end: line stores, 3x3 window, masked sum, divide by nine, output register.
// Depends on bf3z_pkg; pops items from bf3z_queue.
`include "box_filter_3x3_zero_border_unit_macros.svh"
module bf3z_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              head_valid,
    input  bf3z_pkg::item_t   head_item,
    output logic              pop,
    output logic              m_valid,
    input  logic              m_ready,
    output bf3z_pkg::sample_t m_filtered_value,
    output logic              m_last_of_frame
);
    import bf3z_pkg::*;

    sample_t upper_mem  [MAX_SIZE];
    sample_t middle_mem [MAX_SIZE];

    logic    adv;
    sample_t rd_top_reg, rd_mid_reg;
    sample_t top_eff, mid_eff;
    logic    fwd_reg;
    sample_t fwd_top_reg, fwd_mid_reg;

    logic    s1_valid_reg;
    item_t   s1_item_reg;

    sample_t win_reg [3][3];

    logic    s2_valid_reg;
    logic    s2_top_reg, s2_bot_reg, s2_left_reg, s2_right_reg, s2_last_reg;

    logic signed [ROW_BITS-1:0] row_sum [3];
    logic signed [ROW_BITS-1:0] row_sum_reg [3];
    logic    s3_valid_reg, s3_last_reg;

    logic signed [SUM_BITS-1:0] total;
    logic [MAG_BITS-1:0]        mag;
    logic [MAG_BITS-1:0]        mag_reg;
    logic    s4_valid_reg, s4_last_reg, s4_neg_reg;

    logic [PROD_BITS-1:0] prod_reg;
    logic    s5_valid_reg, s5_last_reg, s5_neg_reg;

    sample_t quo;

    logic    m_valid_reg;
    sample_t m_value_reg;
    logic    m_last_reg;

    assign adv     = !m_valid_reg || m_ready;
    assign pop     = adv && head_valid;
    assign top_eff = fwd_reg ? fwd_top_reg : rd_top_reg;
    assign mid_eff = fwd_reg ? fwd_mid_reg : rd_mid_reg;

    assign m_valid          = m_valid_reg;
    assign m_filtered_value = m_value_reg;
    assign m_last_of_frame  = m_last_reg;

    // line stores: read on pop, write back one stage later
    always_ff @(posedge aclk) begin
        if (pop) begin
            rd_top_reg <= upper_mem[head_item.addr];
            rd_mid_reg <= middle_mem[head_item.addr];
        end
        if (adv && s1_valid_reg) begin
            upper_mem[s1_item_reg.addr]  <= mid_eff;
            middle_mem[s1_item_reg.addr] <= s1_item_reg.s;
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            row_sum[i] = ROW_BITS'(win_reg[i][1]);
            if (s2_left_reg) begin
                row_sum[i] = row_sum[i] + ROW_BITS'(win_reg[i][0]);
            end
            if (s2_right_reg) begin
                row_sum[i] = row_sum[i] + ROW_BITS'(win_reg[i][2]);
            end
        end
        if (!s2_top_reg) begin
            row_sum[0] = '0;
        end
        if (!s2_bot_reg) begin
            row_sum[2] = '0;
        end
        total = SUM_BITS'(row_sum_reg[0]) + SUM_BITS'(row_sum_reg[1])
              + SUM_BITS'(row_sum_reg[2]);
        mag   = (total < 0) ? $unsigned(-total) : $unsigned(total);
        mag   = mag + MAG_BITS'(4);
        quo   = sample_t'(prod_reg[PROD_BITS-1:DIV_SHIFT]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_reg      <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    win_reg[i][j] <= '0;
                end
            end
        end else if (adv) begin
            // forward the write of the stage ahead when it hits the same address
            fwd_reg      <= pop && s1_valid_reg && (head_item.addr == s1_item_reg.addr);
            s1_valid_reg <= head_valid;
            if (s1_valid_reg) begin
                for (int i = 0; i < 3; i++) begin
                    win_reg[i][0] <= win_reg[i][1];
                    win_reg[i][1] <= win_reg[i][2];
                end
                win_reg[0][2] <= top_eff;
                win_reg[1][2] <= mid_eff;
                win_reg[2][2] <= s1_item_reg.s;
            end
            s2_valid_reg <= s1_valid_reg && s1_item_reg.has_result;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
            m_valid_reg  <= s5_valid_reg;
        end
    end

    // payload stages
    always_ff @(posedge aclk) begin
        if (adv) begin
            fwd_top_reg  <= mid_eff;
            fwd_mid_reg  <= s1_item_reg.s;
            if (head_valid) begin
                s1_item_reg <= head_item;
            end
            s2_top_reg   <= s1_item_reg.keep_top;
            s2_bot_reg   <= s1_item_reg.keep_bot;
            s2_left_reg  <= s1_item_reg.keep_left;
            s2_right_reg <= s1_item_reg.keep_right;
            s2_last_reg  <= s1_item_reg.last;
            row_sum_reg  <= row_sum;
            s3_last_reg  <= s2_last_reg;
            mag_reg      <= mag;
            s4_neg_reg   <= total < 0;
            s4_last_reg  <= s3_last_reg;
            prod_reg     <= PROD_BITS'(mag_reg) * PROD_BITS'(DIV_MUL);
            s5_neg_reg   <= s4_neg_reg;
            s5_last_reg  <= s4_last_reg;
            m_value_reg  <= s5_neg_reg ? -quo : quo;
            m_last_reg   <= s5_last_reg;
        end
    end

    `BF3Z_ASSERT_IMM(a_fwd_has_item, aclk, aresetn, fwd_reg, s1_valid_reg, "forward without item")
    `BF3Z_ASSERT_NXT(a_stall_holds, aclk, aresetn, !adv, $stable(s5_valid_reg), "stall lost item")

endmodule

// ===== sv/box_filter_3x3_zero_border_unit.sv =====
// 3x3 box filter with zero border over a square grid of signed Q8.8 samples.
// Takes one item per clock while the queue is not full: a front end tracks the raster
// position, a four-entry queue decouples it from a six-stage back end (line store read,
// window, row sums, magnitude, multiply by reciprocal of nine, output register). The item
// completing a neighborhood comes one row plus one after its center sample, so
// grid_size + 1 drain items follow each frame. Line stores need no clearing pass.
// Write grid_size only while idle; a write restarts the frame.
// Depends on bf3z_pkg, bf3z_front, bf3z_queue, bf3z_back.
module box_filter_3x3_zero_border_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [bf3z_pkg::POS_BITS-1:0] cfg_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_cmd,
    input  bf3z_pkg::sample_t             s_sample_in,
    output logic                          m_valid,
    input  logic                          m_ready,
    output bf3z_pkg::sample_t             m_filtered_value,
    output logic                          m_last_of_frame
);
    import bf3z_pkg::*;

    logic  q_full;
    logic  q_push;
    item_t q_item;
    logic  q_pop;
    logic  q_head_valid;
    item_t q_head_item;

    bf3z_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_cmd       (s_cmd),
        .s_sample_in (s_sample_in),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_item      (q_item)
    );

    bf3z_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_item  (q_item),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_item  (q_head_item)
    );

    bf3z_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .head_valid       (q_head_valid),
        .head_item        (q_head_item),
        .pop              (q_pop),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_filtered_value (m_filtered_value),
        .m_last_of_frame  (m_last_of_frame)
    );

endmodule
